>>> design/hefd_pkg.sv
package hefd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLETE_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_IDX   = 8'd1;

    localparam logic [7:0] COMPLETE_CODE_RST = 8'd14;
    localparam logic [7:0] STATUS_CODE_RST   = 8'd15;

    localparam logic [7:0] CC_MIN_LEN = 8'd3;
    localparam logic [7:0] CS_LEN     = 8'd4;

    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    typedef enum logic [2:0] {
        OUT_OTHER    = 3'd0,
        OUT_COMPLETE = 3'd1,
        OUT_STATUS   = 3'd2,
        OUT_TRUNC    = 3'd3,
        OUT_BAD_LEN  = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  evt_code;
        logic [7:0]  param_length;
        logic [7:0]  num_cmd_packets;
        logic [15:0] cmd_opcode;
        logic [7:0]  cmd_status;
        logic [7:0]  return_param_length;
    } t_out_word;

    // One finished buffer, handed from the byte front end to the classifier.
    typedef struct packed {
        logic       trunc;
        logic [7:0] evt_code;
        logic [7:0] param_length;
        logic [7:0] param0;
        logic [7:0] param1;
        logic [7:0] param2;
        logic [7:0] param3;
    } t_frame;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

endpackage

>>> design/hefd_front.sv
module hefd_front
    import hefd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_frame   o_frame
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_plen, n_plen;
    logic [7:0]       r_p0, n_p0;
    logic [7:0]       r_p1, n_p1;
    logic [7:0]       r_p2, n_p2;
    logic [7:0]       r_p3, n_p3;
    logic             accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_code = r_code;
        n_plen = r_plen;
        n_p0   = r_p0;
        n_p1   = r_p1;
        n_p2   = r_p2;
        n_p3   = r_p3;
        unique case (r_count)
            9'd0: n_code = i_in_word.data_byte;
            9'd1: n_plen = i_in_word.data_byte;
            9'd2: n_p0   = i_in_word.data_byte;
            9'd3: n_p1   = i_in_word.data_byte;
            9'd4: n_p2   = i_in_word.data_byte;
            9'd5: n_p3   = i_in_word.data_byte;
            default: ;
        endcase
        n_count = (r_count == CNT_MAX) ? r_count : r_count + 9'd1;
    end

    assign o_push             = accept && i_in_word.last_byte;
    assign o_frame.trunc      = (n_count < 9'd2) || ({1'b0, n_plen} + 9'd2 > n_count);
    assign o_frame.evt_code   = n_code;
    assign o_frame.param_length = n_plen;
    assign o_frame.param0     = n_p0;
    assign o_frame.param1     = n_p1;
    assign o_frame.param2     = n_p2;
    assign o_frame.param3     = n_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            // start the next buffer from a clean frame
            r_count <= '0;
            r_code  <= '0;
            r_plen  <= '0;
            r_p0    <= '0;
            r_p1    <= '0;
            r_p2    <= '0;
            r_p3    <= '0;
        end else if (accept) begin
            r_count <= n_count;
            r_code  <= n_code;
            r_plen  <= n_plen;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
        end
    end

endmodule

>>> design/hefd_queue.sv
module hefd_queue
    import hefd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_frame o_frame
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    t_frame            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_fill;
    logic              do_push, do_pop;

    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == CNT_FULL);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CNT_QW'(1);
            end
        end
    end

endmodule

>>> design/hefd_back.sv
module hefd_back
    import hefd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_head_valid,
    input  t_frame    i_head,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic [7:0] r_complete_code;
    logic [7:0] r_status_code;
    logic       r_out_valid;
    t_out_word  r_out_word, n_out_word;
    t_outcome   outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complete_code <= COMPLETE_CODE_RST;
            r_status_code   <= STATUS_CODE_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_COMPLETE_IDX) begin
                r_complete_code <= i_cfg.data;
            end
            if (i_cfg.index == CFG_STATUS_IDX) begin
                r_status_code <= i_cfg.data;
            end
        end
    end

    // Complete check comes first when both registers hold the same code.
    always_comb begin
        n_out_word = '0;
        outcome    = OUT_OTHER;
        if (i_head.trunc) begin
            outcome = OUT_TRUNC;
        end else begin
            n_out_word.evt_code     = i_head.evt_code;
            n_out_word.param_length = i_head.param_length;
            if (i_head.evt_code == r_complete_code) begin
                if (i_head.param_length < CC_MIN_LEN) begin
                    outcome = OUT_BAD_LEN;
                end else begin
                    outcome = OUT_COMPLETE;
                    n_out_word.num_cmd_packets     = i_head.param0;
                    n_out_word.cmd_opcode          = {i_head.param2, i_head.param1};
                    n_out_word.return_param_length = i_head.param_length - CC_MIN_LEN;
                end
            end else if (i_head.evt_code == r_status_code) begin
                if (i_head.param_length != CS_LEN) begin
                    outcome = OUT_BAD_LEN;
                end else begin
                    outcome = OUT_STATUS;
                    n_out_word.cmd_status      = i_head.param0;
                    n_out_word.num_cmd_packets = i_head.param1;
                    n_out_word.cmd_opcode      = {i_head.param3, i_head.param2};
                end
            end
        end
        if (i_head.trunc) begin
            n_out_word = '0;
        end
        n_out_word.outcome = outcome;
    end

    // Refill the output register when it is empty or its word is taken.
    assign o_pop = i_head_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> design/hci_event_frame_decoder.sv
// HCI event frame decoder.
// Input channel: one byte of an event buffer per word (i_in_word), with
// last_byte set on the buffer's final byte; a word moves when i_in_valid is
// high and o_in_stall is low. Output channel: one classified result per
// buffer on o_out_word, moved when o_out_valid is high and i_out_stall low.
// Configuration: i_cfg_valid/o_cfg_ready write the complete (index 0) and
// status (index 1) event codes; o_cfg_ready is always high. Write only idle.
// Throughput: one byte per cycle while o_in_stall is low. The front end
// counts and captures bytes; a finished buffer goes through a small queue
// to the classifier, which fills the output register. A finished buffer is
// written into the queue, and its result then into the output register.
// When the receiver stalls, the output register holds its word, the queue
// absorbs further finished buffers, and o_in_stall rises only once the
// queue is full; bytes of a buffer in progress still flow until then.
// Reset: frame state and queue are cleared, no result is pending, and the
// event codes return to 14 (complete) and 15 (status).
module hci_event_frame_decoder
    import hefd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic    push, pop, full, head_valid;
    t_frame  push_frame, head_frame;
    t_cfg_wr cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    hefd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    hefd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_full  (full),
        .o_frame (head_frame)
    );

    hefd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_head_valid (head_valid),
        .i_head       (head_frame),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

endmodule
